// File: rtl/lifn_pkg.sv
// Shared types and constants for the LIF neuron step core.
package lifn_pkg;

  localparam int VOLT_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int SAMPLE_W  = 24;
  localparam int COUNT_W   = 23;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 28;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DT_OVER_TAUM       = 3'd0,
    REG_SYN_GAIN           = 3'd1,
    REG_INHIB_REVERSAL     = 3'd2,
    REG_V_THRESH           = 3'd3,
    REG_V_RESET            = 3'd4,
    REG_V_REST             = 3'd5,
    REG_V_SPIKE            = 3'd6,
    REG_REFRACTORY_SAMPLES = 3'd7
  } cfg_reg_t;

  localparam logic [CFG_W-1:0]         RST_DT_OVER_TAUM       = 16'd655;
  localparam logic [CFG_W-1:0]         RST_SYN_GAIN           = 16'd256;
  localparam logic signed [VOLT_W-1:0] RST_INHIB_REVERSAL     = -16'sd20480;
  localparam logic signed [VOLT_W-1:0] RST_V_THRESH           = -16'sd12800;
  localparam logic signed [VOLT_W-1:0] RST_V_RESET            = -16'sd15360;
  localparam logic signed [VOLT_W-1:0] RST_V_REST             = -16'sd16640;
  localparam logic signed [VOLT_W-1:0] RST_V_SPIKE            = 16'sd12800;
  localparam logic [CFG_W-1:0]         RST_REFRACTORY_SAMPLES = 16'd10;

  typedef struct packed {
    logic [CFG_W-1:0]         dt_over_taum;
    logic [CFG_W-1:0]         syn_gain;
    logic signed [VOLT_W-1:0] inhib_reversal;
    logic signed [VOLT_W-1:0] v_thresh;
    logic signed [VOLT_W-1:0] v_reset;
    logic signed [VOLT_W-1:0] v_rest;
    logic signed [VOLT_W-1:0] v_spike;
    logic [CFG_W-1:0]         refractory_samples;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SYN,
    ST_DV,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_GD,
    MUL_SYN,
    MUL_DV
  } mul_sel_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     mul_en;
    logic     load;
    logic     commit;
  } dp_cmd_t;

  typedef struct packed {
    logic skip_pending;
  } dp_stat_t;

endpackage

// File: rtl/lifn_ctrl.sv
// Step sequencer and output handshake control for the LIF neuron core.
module lifn_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_start_req,
  output logic               out_valid,
  input  logic               out_ready,
  input  lifn_pkg::dp_stat_t stat,
  output lifn_pkg::dp_cmd_t  cmd
);
  import lifn_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // start and skipped samples need no arithmetic
          if (in_start_req || stat.skip_pending) state_nxt = ST_DONE;
          else                                   state_nxt = ST_SYN;
        end
      end
      ST_SYN:  state_nxt = ST_DV;
      ST_DV:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.mul_sel = MUL_GD;
    cmd.mul_en  = 1'b0;
    cmd.load    = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load    = accept;
        cmd.mul_en  = accept;
        cmd.mul_sel = MUL_GD;
      end
      ST_SYN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SYN;
      end
      ST_DV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DV;
      end
      ST_DONE: begin
        cmd.commit = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.commit)     out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/lifn_dp.sv
// Datapath: shared multiplier, Euler update, neuron state and result register.
module lifn_dp #(
  parameter int INDEX_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lifn_pkg::cfg_t                        cfg,
  input  lifn_pkg::dp_cmd_t                     cmd,
  output lifn_pkg::dp_stat_t                    stat,
  input  logic                                  in_start_req,
  input  logic [15:0]                           in_syn_drive,
  input  logic signed [lifn_pkg::VOLT_W-1:0]    in_drive_current_mv,
  input  logic signed [lifn_pkg::VOLT_W-1:0]    in_noise_mv,
  output logic signed [lifn_pkg::VOLT_W-1:0]    out_voltage_mv,
  output logic                                  out_spike,
  output logic [lifn_pkg::SAMPLE_W-1:0]         out_sample_index,
  output logic [lifn_pkg::COUNT_W-1:0]          out_spike_count
);
  import lifn_pkg::*;

  localparam int SW = (INDEX_BITS > SAMPLE_W) ? INDEX_BITS : SAMPLE_W;
  localparam int NW = ((INDEX_BITS > CFG_W) ? INDEX_BITS : CFG_W) + 1;
  localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

  // neuron state
  logic signed [VOLT_W-1:0] v_r, v_nxt;
  logic [INDEX_BITS-1:0]    sc_r, sc_nxt;
  logic [INDEX_BITS-1:0]    na_r, na_nxt;
  logic                     skip_r, skip_nxt;
  logic [COUNT_W-1:0]       cnt_r, cnt_nxt;

  // captured item
  logic                     start_r;
  logic signed [VOLT_W-1:0] cur_r;
  logic signed [VOLT_W-1:0] noise_r;

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_r;

  logic signed [VOLT_W:0]    diff;
  logic signed [PROD_W-1:0]  syn_full;
  logic signed [MUL_B_W-1:0] sum;
  logic signed [PROD_W-1:0]  dv_full;
  logic signed [VOLT_W+14:0] vsum;
  logic signed [VOLT_W-1:0]  vsat;
  logic signed [VOLT_W-1:0]  vclamp;

  logic [INDEX_BITS-1:0] sc_inc;
  logic [INDEX_BITS-1:0] ti;
  logic [NW-1:0]         na_sum;
  logic [INDEX_BITS-1:0] na_sat;
  logic [SW-1:0]         sc_ext;

  logic signed [VOLT_W-1:0] vout;
  logic                     spike;

  assign diff = (VOLT_W+1)'(cfg.inhib_reversal) - (VOLT_W+1)'(v_r);

  // round to nearest, ties up, then back to Q7.8
  assign syn_full = (prod_r + (PROD_W'(1) <<< 22)) >>> 23;
  assign sum = syn_full[MUL_B_W-1:0]
             + MUL_B_W'(cfg.v_rest) - MUL_B_W'(v_r)
             + MUL_B_W'(noise_r) + MUL_B_W'(cur_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      MUL_GD: begin
        mul_a = MUL_A_W'(cfg.syn_gain);
        mul_b = MUL_B_W'(in_syn_drive);
      end
      MUL_SYN: begin
        mul_a = {1'b0, prod_r[31:0]};
        mul_b = MUL_B_W'(diff);
      end
      MUL_DV: begin
        mul_a = MUL_A_W'(cfg.dt_over_taum);
        mul_b = sum;
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  assign dv_full = (prod_r + (PROD_W'(1) <<< 15)) >>> 16;
  assign vsum    = (VOLT_W+15)'(v_r) + dv_full[VOLT_W+14:0];

  always_comb begin
    if (vsum > (VOLT_W+15)'(32767))       vsat = 16'sh7FFF;
    else if (vsum < -(VOLT_W+15)'(32768)) vsat = -16'sh8000;
    else                                  vsat = vsum[VOLT_W-1:0];
    vclamp = (vsat < cfg.inhib_reversal) ? cfg.inhib_reversal : vsat;
  end

  assign sc_inc = (sc_r == IDX_MAX) ? sc_r : sc_r + 1'b1;
  assign ti     = sc_inc - 1'b1;
  assign na_sum = NW'(ti) + NW'(cfg.refractory_samples);
  assign na_sat = (na_sum > NW'(IDX_MAX)) ? IDX_MAX : na_sum[INDEX_BITS-1:0];

  always_comb begin
    v_nxt    = v_r;
    sc_nxt   = sc_r;
    na_nxt   = na_r;
    skip_nxt = skip_r;
    cnt_nxt  = cnt_r;
    vout     = v_r;
    spike    = 1'b0;
    priority if (start_r) begin
      v_nxt    = cfg.v_rest;
      sc_nxt   = INDEX_BITS'(1);
      na_nxt   = '0;
      skip_nxt = 1'b0;
      cnt_nxt  = '0;
      vout     = cfg.v_rest;
    end else if (skip_r) begin
      sc_nxt   = sc_inc;
      skip_nxt = 1'b0;
      v_nxt    = cfg.v_reset;
      vout     = cfg.v_reset;
    end else begin
      sc_nxt = sc_inc;
      if (vclamp >= cfg.v_thresh) begin
        if (ti >= na_r) begin
          na_nxt   = na_sat;
          cnt_nxt  = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 1'b1;
          skip_nxt = 1'b1;
          spike    = 1'b1;
          v_nxt    = cfg.v_reset;
          vout     = cfg.v_spike;
        end else begin
          // inside the refractory gap: hold at threshold
          v_nxt = cfg.v_thresh;
          vout  = cfg.v_thresh;
        end
      end else begin
        v_nxt = vclamp;
        vout  = vclamp;
      end
    end
  end

  assign sc_ext = SW'(sc_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      sc_r   <= '0;
      na_r   <= '0;
      skip_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.commit) begin
      v_r    <= v_nxt;
      sc_r   <= sc_nxt;
      na_r   <= na_nxt;
      skip_r <= skip_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_r <= in_start_req;
      cur_r   <= in_drive_current_mv;
      noise_r <= in_noise_mv;
    end
    if (cmd.mul_en) begin
      prod_r <= prod;
    end
    if (cmd.commit) begin
      out_voltage_mv   <= vout;
      out_spike        <= spike;
      out_sample_index <= (sc_ext > SW'(SAMPLE_MAX)) ? SAMPLE_MAX : sc_ext[SAMPLE_W-1:0];
      out_spike_count  <= cnt_nxt;
    end
  end

  assign stat.skip_pending = skip_r;

endmodule

// File: rtl/lif_neuron_inhibitory_step_core.sv
// Top level of the LIF neuron step core: config registers, sequencer and datapath.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | start_req, syn_drive, drive_current_mv, noise_mv
//  out_    | output    | out_valid / out_ready | voltage_mv, spike, sample_index, spike_count
//  cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// An Euler step runs capture plus gain-times-drive product, then the synaptic
// product, the dt/taum product and the commit, all on one shared 33x28
// multiplier. Start and skipped samples go straight from capture to the commit.
// Reset (synchronous, active low) loads register defaults and zeroes the state.
// The result register holds until taken; a new transaction is accepted meanwhile,
// and its commit waits until the result register is free.
module lif_neuron_inhibitory_step_core #(
  parameter int INDEX_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_start_req,
  input  logic [15:0]                           in_syn_drive,
  input  logic signed [lifn_pkg::VOLT_W-1:0]    in_drive_current_mv,
  input  logic signed [lifn_pkg::VOLT_W-1:0]    in_noise_mv,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [lifn_pkg::VOLT_W-1:0]    out_voltage_mv,
  output logic                                  out_spike,
  output logic [lifn_pkg::SAMPLE_W-1:0]         out_sample_index,
  output logic [lifn_pkg::COUNT_W-1:0]          out_spike_count,
  input  logic                                  cfg_we,
  input  logic [lifn_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lifn_pkg::CFG_W-1:0]            cfg_wdata
);
  import lifn_pkg::*;

  cfg_t     cfg_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dt_over_taum       <= RST_DT_OVER_TAUM;
      cfg_r.syn_gain           <= RST_SYN_GAIN;
      cfg_r.inhib_reversal     <= RST_INHIB_REVERSAL;
      cfg_r.v_thresh           <= RST_V_THRESH;
      cfg_r.v_reset            <= RST_V_RESET;
      cfg_r.v_rest             <= RST_V_REST;
      cfg_r.v_spike            <= RST_V_SPIKE;
      cfg_r.refractory_samples <= RST_REFRACTORY_SAMPLES;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DT_OVER_TAUM:       cfg_r.dt_over_taum       <= cfg_wdata;
        REG_SYN_GAIN:           cfg_r.syn_gain           <= cfg_wdata;
        REG_INHIB_REVERSAL:     cfg_r.inhib_reversal     <= cfg_wdata;
        REG_V_THRESH:           cfg_r.v_thresh           <= cfg_wdata;
        REG_V_RESET:            cfg_r.v_reset            <= cfg_wdata;
        REG_V_REST:             cfg_r.v_rest             <= cfg_wdata;
        REG_V_SPIKE:            cfg_r.v_spike            <= cfg_wdata;
        REG_REFRACTORY_SAMPLES: cfg_r.refractory_samples <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lifn_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_start_req (in_start_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  lifn_dp #(
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .cmd                 (cmd),
    .stat                (stat),
    .in_start_req        (in_start_req),
    .in_syn_drive        (in_syn_drive),
    .in_drive_current_mv (in_drive_current_mv),
    .in_noise_mv         (in_noise_mv),
    .out_voltage_mv      (out_voltage_mv),
    .out_spike           (out_spike),
    .out_sample_index    (out_sample_index),
    .out_spike_count     (out_spike_count)
  );

endmodule
